[design/ppc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ppc_pkg;

    localparam int MaxFaceVertices = 16;
    localparam int VidxW = $clog2(MaxFaceVertices + 1);
    localparam int KeepMin = 3;
    localparam logic [9:0] CountMax = 10'd1023;

    typedef enum logic [1:0] {
        REG_NX  = 2'd0,
        REG_NY  = 2'd1,
        REG_NZ  = 2'd2,
        REG_OFS = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               face_end;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               vertex_valid;
        logic               is_intersection;
        logic               last_of_face;
        logic               face_kept;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIST,
        S_DECIDE,
        S_DIV,
        S_INTERP,
        S_EMIT,
        S_WAIT
    } t_state;

    // what an emitted word carries
    typedef enum logic [1:0] {
        K_XING,
        K_VERT,
        K_EMPTY
    } t_kind;

    // edge selection for the interpolator
    typedef enum logic {
        E_PREV,
        E_CLOSE
    } t_edge;

    typedef struct packed {
        logic  load_in;
        logic  mul;
        logic  dist_ld;
        logic  div_start;
        logic  interp;
        t_edge edge_sel;
        logic  emit;
        t_kind kind;
        logic  last;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic face_end;
        logic cur_neg;
        logic prev_neg;
        logic first_neg;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

[design/ppc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire ppc_pkg::t_status i_st,
    output ppc_pkg::t_cmd         o_cmd
);
    import ppc_pkg::*;

    t_state r_state, n_state;
    // pending emissions for this vertex
    logic r_need_x, n_need_x, r_need_v, n_need_v, r_need_c, n_need_c;
    logic r_any, n_any;
    t_kind r_kind, n_kind;
    t_edge r_edge, n_edge;
    logic  r_last, n_last;

    logic need_x, need_v, need_c;
    always_comb begin
        need_x = !i_st.first && (i_st.cur_neg != i_st.prev_neg);
        need_v = !i_st.cur_neg;
        need_c = i_st.face_end && (i_st.cur_neg != i_st.first_neg);
    end

    always_comb begin
        n_state  = r_state;
        n_need_x = r_need_x;
        n_need_v = r_need_v;
        n_need_c = r_need_c;
        n_any    = r_any;
        n_kind   = r_kind;
        n_edge   = r_edge;
        n_last   = r_last;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL;
            S_MUL:  n_state = S_DIST;
            S_DIST: n_state = S_DECIDE;
            S_DECIDE: begin
                n_need_x = r_need_x;
                if (r_need_x) begin
                    n_need_x = 1'b0;
                    n_kind = K_XING; n_edge = E_PREV;
                    n_last = i_st.face_end && !r_need_v && !r_need_c;
                    n_state = S_DIV;
                end else if (r_need_v) begin
                    n_need_v = 1'b0;
                    n_kind = K_VERT;
                    n_last = i_st.face_end && !r_need_c;
                    n_state = S_EMIT;
                end else if (r_need_c) begin
                    n_need_c = 1'b0;
                    n_kind = K_XING; n_edge = E_CLOSE;
                    n_last = 1'b1;
                    n_state = S_DIV;
                end else if (i_st.face_end && !r_any) begin
                    n_kind = K_EMPTY;
                    n_last = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV:    if (i_st.div_done) n_state = S_INTERP;
            S_INTERP: n_state = S_EMIT;
            S_EMIT:   if (!i_st.out_busy) begin
                n_any = 1'b1;
                n_state = S_DECIDE;
            end
            S_WAIT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (r_state == S_DIST) begin
            n_need_x = need_x;
            n_need_v = need_v;
            n_need_c = need_c;
            n_any    = 1'b0;
        end
    end

    always_comb begin
        o_cmd = '0;
        o_stall = (r_state != S_IDLE);
        o_cmd.edge_sel = r_edge;
        o_cmd.kind = r_kind;
        o_cmd.last = r_last;
        unique case (r_state)
            S_IDLE:   o_cmd.load_in = i_valid;
            S_MUL:    o_cmd.mul = 1'b1;
            S_DIST:   o_cmd.dist_ld = 1'b1;
            S_DECIDE: begin
                o_cmd.commit = !r_need_x && !r_need_v && !r_need_c
                               && !(i_st.face_end && !r_any);
                o_cmd.div_start = r_need_x || (!r_need_v && r_need_c);
                o_cmd.edge_sel = r_need_x ? E_PREV : E_CLOSE;
            end
            S_INTERP: o_cmd.interp = 1'b1;
            S_EMIT:   o_cmd.emit = !i_st.out_busy;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_need_x <= 1'b0; r_need_v <= 1'b0; r_need_c <= 1'b0;
            r_any <= 1'b0;
            r_kind <= K_VERT; r_edge <= E_PREV; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_need_x <= n_need_x; r_need_v <= n_need_v; r_need_c <= n_need_c;
            r_any <= n_any;
            r_kind <= n_kind; r_edge <= n_edge; r_last <= n_last;
        end
    end
endmodule
`default_nettype wire

[design/ppc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider: q = min(floor(num * 2^31 / den), 2^31), one bit a cycle
module ppc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_q
);
    import ppc_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [62:0] r_num;
    logic [31:0] r_q;
    logic [33:0] shifted, diff;

    always_comb begin
        shifted = {r_rem[32:0], r_num[62]};
        diff = shifted - {1'b0, r_den};
    end

    assign o_done = r_busy && (r_cnt == 6'd0);
    // |da| <= |da-db| by opposite signs, so q never exceeds 2^31; bit 31 is the cap
    assign o_q = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd63;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= {i_num, 31'd0};
            r_q <= '0;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_num <= {r_num[61:0], 1'b0};
            if (!diff[33]) begin
                r_rem <= diff;
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

[design/ppc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppc_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire ppc_pkg::t_in_word i_word,
    input  wire ppc_pkg::t_cmd     i_cmd,
    output ppc_pkg::t_status       o_st,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output ppc_pkg::t_out_word     o_word
);
    import ppc_pkg::*;

    logic signed [17:0] r_nx, r_ny, r_nz;
    logic signed [31:0] r_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0; r_ny <= '0; r_nz <= 18'sd65536; r_ofs <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_NX:  r_nx <= i_cfg_data[17:0];
                REG_NY:  r_ny <= i_cfg_data[17:0];
                REG_NZ:  r_nz <= i_cfg_data[17:0];
                REG_OFS: r_ofs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [31:0] r_cx, r_cy, r_cz, r_px, r_py, r_pz, r_fx, r_fy, r_fz;
    logic signed [31:0] r_cd, r_pd, r_fd;
    logic               r_end;
    logic [VidxW-1:0]   r_vidx;
    logic [9:0]         r_cnt;
    logic signed [49:0] r_mx, r_my, r_mz;

    // floor shift of the product sum, then offset and saturate
    logic signed [51:0] acc;
    logic signed [52:0] qsum;
    logic signed [31:0] plane_d;
    always_comb begin
        acc = 52'(r_mx) + 52'(r_my) + 52'(r_mz);
        qsum = 53'(acc >>> 16) + 53'(r_ofs);
        if (qsum > 53'sd2147483647) plane_d = 32'sh7FFFFFFF;
        else if (qsum < -53'sd2147483648) plane_d = 32'sh80000000;
        else plane_d = qsum[31:0];
    end

    logic first;
    assign first = (r_vidx == '0);

    // edge endpoints
    logic signed [31:0] ax, ay, az, bx, by, bz, da, db;
    always_comb begin
        if (i_cmd.edge_sel == E_PREV) begin
            ax = r_px; ay = r_py; az = r_pz; da = r_pd;
            bx = r_cx; by = r_cy; bz = r_cz; db = r_cd;
        end else begin
            ax = r_cx; ay = r_cy; az = r_cz; da = r_cd;
            bx = r_fx; by = r_fy; bz = r_fz; db = r_fd;
        end
    end

    logic [31:0] num;
    logic signed [32:0] dd;
    logic [32:0] den;
    always_comb begin
        num = da[31] ? 32'(-33'(da)) : 32'(da);
        dd = 33'(da) - 33'(db);
        den = dd[32] ? 33'(-dd) : 33'(dd);
    end

    logic        div_done;
    logic [31:0] t;
    ppc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (num),
        .i_den  (den),
        .o_done (div_done),
        .o_q    (t)
    );

    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [31:0] tt);
        logic signed [32:0] df;
        logic [32:0] mag;
        logic [64:0] prod;
        logic [33:0] off;
        df = 33'(b) - 33'(a);
        mag = df[32] ? 33'(-df) : 33'(df);
        prod = 65'(tt) * 65'(mag);
        off = 34'(prod >> 31);
        lerp = df[32] ? 32'(34'(a) - off) : 32'(34'(a) + off);
    endfunction

    logic signed [31:0] r_ix, r_iy, r_iz;
    always_ff @(posedge i_clk) begin
        if (i_cmd.interp) begin
            r_ix <= lerp(ax, bx, t);
            r_iy <= lerp(ay, by, t);
            r_iz <= lerp(az, bz, t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cx <= i_word.vert_x; r_cy <= i_word.vert_y; r_cz <= i_word.vert_z;
            r_end <= i_word.face_end;
        end
        if (i_cmd.mul) begin
            r_mx <= r_nx * r_cx;
            r_my <= r_ny * r_cy;
            r_mz <= r_nz * r_cz;
        end
        if (i_cmd.dist_ld) begin
            r_cd <= plane_d;
            if (first) begin
                r_fx <= r_cx; r_fy <= r_cy; r_fz <= r_cz; r_fd <= plane_d;
            end
        end
        if (i_cmd.commit) begin
            r_px <= r_cx; r_py <= r_cy; r_pz <= r_cz; r_pd <= r_cd;
        end
    end

    logic [9:0] cnt_next;
    logic       valid_v;
    assign valid_v = (i_cmd.kind != K_EMPTY);
    assign cnt_next = (valid_v && r_cnt < CountMax) ? r_cnt + 10'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vidx <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.emit) r_cnt <= cnt_next;
            if (i_cmd.commit) begin
                if (r_end) begin
                    r_vidx <= '0;
                    r_cnt <= '0;
                end else if (r_vidx < VidxW'(MaxFaceVertices)) begin
                    r_vidx <= r_vidx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_cmd.emit) o_valid <= 1'b1;
        else if (!i_stall) o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                K_XING: begin
                    o_word.out_x <= r_ix; o_word.out_y <= r_iy; o_word.out_z <= r_iz;
                end
                K_VERT: begin
                    o_word.out_x <= r_cx; o_word.out_y <= r_cy; o_word.out_z <= r_cz;
                end
                default: begin
                    o_word.out_x <= '0; o_word.out_y <= '0; o_word.out_z <= '0;
                end
            endcase
            o_word.vertex_valid <= valid_v;
            o_word.is_intersection <= (i_cmd.kind == K_XING);
            o_word.last_of_face <= i_cmd.last;
            o_word.face_kept <= i_cmd.last && (cnt_next >= 10'(KeepMin));
        end
    end

    // the sum is valid from the sum cycle on, before r_cd and r_fd are loaded
    always_comb begin
        o_st.first = first;
        o_st.face_end = r_end;
        o_st.cur_neg = plane_d[31];
        o_st.prev_neg = r_pd[31];
        o_st.first_neg = first ? plane_d[31] : r_fd[31];
        o_st.div_done = div_done;
        o_st.out_busy = o_valid && i_stall;
    end
endmodule
`default_nettype wire

[design/polygon_plane_clipper_unit.sv]
// Polygon plane clipper: one Sutherland-Hodgman pass against one plane.
// Input channel: i_valid / o_stall with i_word (vertex and face_end flag).
// Output channel: o_valid / i_stall with o_word; a word moves when valid is
// high and stall low. Config: i_cfg_we, i_cfg_idx, i_cfg_data; write only
// while idle.
// A vertex is accepted in idle, then passes through multiply, sum and decide,
// and returns to idle when it emits nothing. Each output word adds: a kept
// vertex load and decide, an intersection the 1-bit-per-cycle restoring
// divider, interpolate, load and decide. Up to three words per vertex.
// o_stall is high while a vertex is in work.
// The output register holds a word until taken; while the receiver stalls
// the controller waits before loading the next word.
// Reset (synchronous, active low) sets the plane to z >= 0, clears the face
// state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module polygon_plane_clipper_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire ppc_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ppc_pkg::t_out_word      o_word,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import ppc_pkg::*;

    t_cmd    cmd;
    t_status st;

    ppc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_st   (st),
        .o_cmd  (cmd)
    );

    ppc_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_word    (i_word),
        .i_cmd     (cmd),
        .o_st      (st),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_word    (o_word)
    );
endmodule
`default_nettype wire
